FILE: hw/rtl/wlm_pkg.sv
// package for the windowed latency monitor: sizes, types and register indexes
package wlm_pkg;

    localparam int unsigned SLOTS_DEF  = 16;
    localparam int unsigned WINDOW_DEF = 1024;

    // configuration register indexes
    localparam logic [0:0] REG_ENABLE = 1'b0;
    localparam logic [0:0] REG_TPS    = 1'b1;
    localparam logic [31:0] TPS_RESET = 32'd1000000;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_END   = 1'b1;

    // per-slot record held in the slot memory
    typedef struct packed {
        logic        used;
        logic        running;
        logic [63:0] stamp;
        logic [31:0] ops;
        logic [11:0] wpos;
        logic [12:0] fill;
        logic [31:0] calls;
        logic [41:0] sum;
        logic [31:0] min;
        logic [31:0] max;
        logic [31:0] avg;
        logic [63:0] rate;
    } t_slot;

    typedef struct packed {
        logic        ok;
        logic [31:0] elapsed;
        logic [31:0] call_total;
        logic [10:0] window_fill;
        logic [41:0] window_sum;
        logic [31:0] window_min;
        logic [31:0] window_max;
        logic [31:0] window_avg;
        logic [63:0] rate;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DECIDE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_DIV_AVG,
        ST_MUL,
        ST_DIV_RATE,
        ST_WRITE,
        ST_OUT
    } t_state;

endpackage

FILE: hw/rtl/wlm_if.sv
// valid/ready channel interface carrying one item
interface wlm_if #(parameter int unsigned W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/wlm_ram.sv
// generic single-port ram with registered read
module wlm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // read before write, read registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: hw/rtl/windowed_latency_monitor.sv
// top level: interval timers with sliding window latency statistics
//
//  channel | dir | payload
//  i_in    | in  | action, timer_id, timestamp, op_count
//  o_out   | out | ok, elapsed, call_total, window_fill, window_sum,
//          |     | window_min, window_max, window_avg, rate
//  apb     | in  | enable (0x0), ticks_per_second (0x4)
//
// one item at a time; an end item passes read, decide, a scan of the window,
// two bit-serial divisions (average, then rate), write and output, and skips
// the rate division when the rate is left alone. a start passes read, decide,
// write and output, a failed item read, decide and output; the block returns
// to idle before the next item. reset clears the slot valid bits; the
// sample memory needs no clearing. a stalled result holds in the output
// register while the next item is worked on; that item waits in the output
// state until the register is free.
module windowed_latency_monitor
    import wlm_pkg::*;
#(
    parameter int unsigned SLOTS  = SLOTS_DEF,
    parameter int unsigned WINDOW = WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wlm_if.sink         i_in,
    wlm_if.source       o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned WW = $clog2(WINDOW);
    localparam int unsigned AW = SW + WW;

    // configuration registers
    logic        r_enable;
    logic [31:0] r_tps;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_tps    <= TPS_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_ENABLE && paddr[1:0] == 2'b00) r_enable <= pwdata[0];
            if (paddr[2] == REG_TPS && paddr[1:0] == 2'b00)    r_tps <= pwdata;
        end
    end
    always_comb begin
        prdata = 32'd0;
        if (paddr == 3'd0) prdata = {31'd0, r_enable};
        else if (paddr == 3'd4) prdata = r_tps;
    end

    // payload fields
    logic        in_action;
    logic [3:0]  in_id;
    logic [63:0] in_stamp;
    logic [31:0] in_ops;
    assign {in_action, in_id, in_stamp, in_ops} = i_in.data;

    t_state r_state, n_state;
    logic   [3:0]  r_id;
    logic          r_action;
    logic   [63:0] r_stamp;
    logic   [31:0] r_ops_in;
    logic          r_inrange;
    t_slot         r_slot;
    logic   [31:0] r_elapsed;
    logic          r_ok;
    logic   [12:0] r_idx;
    logic   [43:0] r_tot;
    logic   [31:0] r_lo, r_hi;
    logic   [6:0]  r_dcnt;
    logic   [63:0] r_quo;
    logic   [63:0] r_rem;
    logic   [63:0] r_num;
    logic   [31:0] r_den;
    logic          r_valid_slot [SLOTS];
    t_result       r_res;
    logic          r_oval;
    logic          out_load;

    // slot record memory and sample memory
    logic          slot_we;
    t_slot         slot_rd, slot_wd;
    logic [SW-1:0] slot_addr;
    logic          smp_we;
    logic [AW-1:0] smp_addr;
    logic [31:0]   smp_rd;
    logic [WW-1:0] wr_pos;

    wlm_ram #(.WIDTH($bits(t_slot)), .DEPTH(1 << SW)) u_slot_ram (
        .i_clk(i_clk), .i_we(slot_we), .i_addr(slot_addr),
        .i_wdata(slot_wd), .o_rdata(slot_rd));
    wlm_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_smp_ram (
        .i_clk(i_clk), .i_we(smp_we), .i_addr(smp_addr),
        .i_wdata(r_elapsed), .o_rdata(smp_rd));

    // the slot record is fetched at the accepting edge
    assign slot_addr = (r_state == ST_IDLE) ? in_id[SW-1:0] : r_id[SW-1:0];
    assign slot_wd   = r_slot;
    assign slot_we   = (r_state == ST_WRITE);
    assign wr_pos    = (r_slot.fill < 13'(WINDOW)) ? r_slot.fill[WW-1:0] : r_slot.wpos[WW-1:0];
    assign smp_we    = (r_state == ST_DECIDE) && r_ok && r_action;
    assign smp_addr  = {r_id[SW-1:0], (r_state == ST_DECIDE) ? wr_pos : r_idx[WW-1:0]};

    // output register loads once the previous result is gone or leaving
    assign out_load    = (r_state == ST_OUT) && (!r_oval || o_out.ready);
    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_oval;
    assign o_out.data  = r_res;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (i_in.valid) n_state = ST_READ;
            ST_READ:      n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (r_ok && r_action) n_state = ST_SCAN;
                else if (r_ok) n_state = ST_WRITE;
                else n_state = ST_OUT;
            end
            ST_SCAN:      if (r_idx + 13'd1 >= r_slot.fill) n_state = ST_SCAN_LAST;
            ST_SCAN_LAST: n_state = ST_DIV_AVG;
            ST_DIV_AVG:   if (r_dcnt == 7'd0) n_state = ST_MUL;
            ST_MUL:       n_state = (r_slot.ops != 0 && r_quo[31:0] != 0) ? ST_DIV_RATE : ST_WRITE;
            ST_DIV_RATE:  if (r_dcnt == 7'd0) n_state = ST_WRITE;
            ST_WRITE:     n_state = ST_OUT;
            ST_OUT:       if (out_load) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // divider step: restoring, one quotient bit per cycle
    logic [64:0] d_rem;
    logic        d_ge;
    always_comb begin
        d_rem = {r_rem, r_num[63]};
        d_ge  = d_rem >= {33'd0, r_den};
    end

    logic [63:0] d_diff;
    assign d_diff = 64'(d_rem - {33'd0, r_den});
    logic [63:0] elapsed64;
    assign elapsed64 = (r_stamp >= slot_rd.stamp) ? r_stamp - slot_rd.stamp : 64'd0;

    // record of a never-written slot
    t_slot slot_empty;
    always_comb begin
        slot_empty     = '0;
        slot_empty.min = '1;
    end

    // start and end checks on the fetched record
    logic rd_valid, start_ok, end_ok;
    assign rd_valid = r_inrange && r_valid_slot[r_id[SW-1:0]];
    assign start_ok = r_inrange && r_enable && (r_action == ACT_START) &&
                      !(rd_valid && slot_rd.running);
    assign end_ok   = r_inrange && r_enable && (r_action == ACT_END) &&
                      rd_valid && slot_rd.used && slot_rd.running;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_oval  <= 1'b0;
            for (int i = 0; i < SLOTS; i++) r_valid_slot[i] <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) r_oval <= 1'b1;
            else if (o_out.valid && o_out.ready) r_oval <= 1'b0;
            case (r_state)
                ST_IDLE: if (i_in.valid) begin
                    r_action  <= in_action;
                    r_id      <= in_id;
                    r_stamp   <= in_stamp;
                    r_ops_in  <= in_ops;
                    r_inrange <= (32'(in_id) < SLOTS);
                end
                ST_READ: begin
                    // record of the slot, reset value when never written
                    r_slot    <= rd_valid ? slot_rd : slot_empty;
                    r_ok      <= start_ok || end_ok;
                    r_elapsed <= !end_ok ? 32'd0 :
                                 (elapsed64 > 64'hFFFFFFFF) ? '1 : elapsed64[31:0];
                end
                ST_DECIDE: begin
                    r_idx <= 13'd0;
                    r_tot <= '0;
                    r_lo  <= '1;
                    r_hi  <= '0;
                    if (r_ok && r_action == ACT_START) begin
                        r_slot.used    <= 1'b1;
                        r_slot.running <= 1'b1;
                        r_slot.ops     <= r_ops_in;
                        r_slot.stamp   <= r_stamp;
                    end else if (r_ok) begin
                        r_slot.running <= 1'b0;
                        if (r_slot.fill < 13'(WINDOW)) r_slot.fill <= r_slot.fill + 13'd1;
                        else r_slot.wpos <= (r_slot.wpos[WW-1:0] == WW'(WINDOW - 1)) ?
                                            12'd0 : r_slot.wpos + 12'd1;
                        if (r_slot.calls != '1) r_slot.calls <= r_slot.calls + 32'd1;
                    end
                end
                ST_SCAN: begin
                    if (r_idx != 13'd0) begin
                        r_tot <= r_tot + 44'(smp_rd);
                        if (smp_rd < r_lo) r_lo <= smp_rd;
                        if (smp_rd > r_hi) r_hi <= smp_rd;
                    end
                    r_idx <= r_idx + 13'd1;
                end
                ST_SCAN_LAST: begin
                    r_tot <= r_tot + 44'(smp_rd);
                    if (smp_rd < r_lo) r_lo <= smp_rd;
                    if (smp_rd > r_hi) r_hi <= smp_rd;
                    r_num  <= 64'(r_tot + 44'(smp_rd));
                    r_den  <= 32'(r_slot.fill);
                    r_rem  <= '0;
                    r_dcnt <= 7'd63;
                end
                ST_DIV_AVG, ST_DIV_RATE: begin
                    r_rem  <= d_ge ? d_diff : d_rem[63:0];
                    r_quo  <= {r_quo[62:0], d_ge};
                    r_num  <= {r_num[62:0], 1'b0};
                    r_dcnt <= r_dcnt - 7'd1;
                    if (r_state == ST_DIV_RATE && r_dcnt == 7'd0)
                        r_slot.rate <= {r_quo[62:0], d_ge};
                end
                ST_MUL: begin
                    r_slot.sum <= (r_tot > 44'h3FFFFFFFFFF) ? '1 : r_tot[41:0];
                    r_slot.min <= r_lo;
                    r_slot.max <= r_hi;
                    r_slot.avg <= r_quo[31:0];
                    r_num  <= r_slot.ops * r_tps;
                    r_den  <= r_quo[31:0];
                    r_rem  <= '0;
                    r_dcnt <= 7'd63;
                end
                ST_WRITE: r_valid_slot[r_id[SW-1:0]] <= 1'b1;
                ST_OUT: if (out_load) begin
                    r_res.ok          <= r_ok;
                    r_res.elapsed     <= r_elapsed;
                    r_res.call_total  <= r_slot.calls;
                    r_res.window_fill <= r_slot.fill[10:0];
                    r_res.window_sum  <= r_slot.sum;
                    r_res.window_min  <= r_slot.min;
                    r_res.window_max  <= r_slot.max;
                    r_res.window_avg  <= r_slot.avg;
                    r_res.rate        <= r_slot.rate;
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: tb/sv/tb.sv
// testbench for the windowed latency monitor: directed table, random intervals, one busy slot
`timescale 1ns / 1ps

module tb
    import wlm_pkg::*;
();

    localparam int unsigned NSLOT  = SLOTS_DEF;
    localparam int unsigned NWIN   = WINDOW_DEF;
    localparam int unsigned LIMIT  = 8000000;
    localparam int unsigned FILL_PAIRS = 20;
    localparam int unsigned RAND_ITEMS = 480;

    // input item as carried on the channel, action in the top bit
    typedef struct packed {
        logic        action;
        logic [3:0]  timer_id;
        logic [63:0] timestamp;
        logic [31:0] op_count;
    } t_item;

    typedef enum logic [1:0] {ROW_ITEM, ROW_ENABLE, ROW_TPS} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        action;
        logic [3:0]  timer_id;
        logic [63:0] timestamp;
        logic [31:0] op_count;
        logic        typed;
        logic [31:0] value;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    wlm_if #(.W($bits(t_item)))   in_ch ();
    wlm_if #(.W($bits(t_result))) out_ch ();

    windowed_latency_monitor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the monitor state
    logic [31:0] win_samples [NSLOT][NWIN];
    logic        sl_used [NSLOT];
    logic        sl_running [NSLOT];
    logic [63:0] sl_stamp [NSLOT];
    logic [31:0] sl_ops [NSLOT];
    int unsigned sl_wpos [NSLOT];
    int unsigned sl_fill [NSLOT];
    logic [31:0] sl_calls [NSLOT];
    logic [41:0] sl_sum [NSLOT];
    logic [31:0] sl_min [NSLOT];
    logic [31:0] sl_max [NSLOT];
    logic [31:0] sl_avg [NSLOT];
    logic [63:0] sl_rate [NSLOT];
    logic        cfg_enable;
    logic [31:0] cfg_tps;

    t_result     results_due [$];
    int unsigned errors_seen = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left = 0;
    logic        calm_mode;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // rescan the window of one slot, as the block does after every closed interval
    function automatic void rescan_slot(input int unsigned s);
        logic [63:0] total;
        logic [31:0] lo, hi, avg;
        total = '0;
        lo = '1;
        hi = '0;
        if (sl_fill[s] == 0) return;
        for (int unsigned i = 0; i < sl_fill[s]; i++) begin
            total += win_samples[s][i];
            if (win_samples[s][i] < lo) lo = win_samples[s][i];
            if (win_samples[s][i] > hi) hi = win_samples[s][i];
        end
        avg = 32'(total / sl_fill[s]);
        sl_sum[s] = (total > 64'h3FF_FFFF_FFFF) ? 42'h3FF_FFFF_FFFF : total[41:0];
        sl_min[s] = lo;
        sl_max[s] = hi;
        sl_avg[s] = avg;
        if (sl_ops[s] != 0 && avg != 0)
            sl_rate[s] = (64'(sl_ops[s]) * 64'(cfg_tps)) / 64'(avg);
    endfunction

    // expected result of one item, updating the shadow state
    function automatic t_result stats_predict(input t_item it);
        t_result r;
        int unsigned s;
        logic [63:0] d;
        logic [31:0] el;
        logic ok;
        s = it.timer_id;
        ok = 1'b0;
        el = '0;
        if (cfg_enable) begin
            if (it.action == ACT_START) begin
                if (!sl_running[s]) begin
                    sl_used[s] = 1'b1;
                    sl_ops[s] = it.op_count;
                    sl_stamp[s] = it.timestamp;
                    sl_running[s] = 1'b1;
                    ok = 1'b1;
                end
            end else if (sl_used[s] && sl_running[s]) begin
                d = (it.timestamp >= sl_stamp[s]) ? it.timestamp - sl_stamp[s] : '0;
                el = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
                sl_running[s] = 1'b0;
                if (sl_fill[s] < NWIN) begin
                    win_samples[s][sl_fill[s]] = el;
                    sl_fill[s]++;
                end else begin
                    win_samples[s][sl_wpos[s]] = el;
                    sl_wpos[s] = (sl_wpos[s] + 1) % NWIN;
                end
                if (sl_calls[s] != 32'hFFFF_FFFF) sl_calls[s]++;
                rescan_slot(s);
                ok = 1'b1;
            end
        end
        r.ok          = ok;
        r.elapsed     = el;
        r.call_total  = sl_calls[s];
        r.window_fill = 11'(sl_fill[s]);
        r.window_sum  = sl_sum[s];
        r.window_min  = sl_min[s];
        r.window_max  = sl_max[s];
        r.window_avg  = sl_avg[s];
        r.rate        = sl_rate[s];
        return r;
    endfunction

    // result of a failed item on an untouched slot
    function automatic t_result empty_fail();
        t_result r;
        r = '0;
        r.window_min = '1;
        return r;
    endfunction

    task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", field, got, want, cycle_count);
        errors_seen++;
    endtask

    // send one item with a random gap ahead of it; predict on acceptance
    task automatic send_item(input t_item it, input logic typed, input t_result typed_res);
        int unsigned gap;
        int unsigned pick;
        t_result r;
        pick = $urandom_range(0, 99);
        if (calm_mode || pick < 60) gap = 0;
        else if (pick < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 60);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        // ready is settled mid-cycle; the following edge accepts
        do @(negedge i_clk); while (!in_ch.ready);
        @(posedge i_clk);
        r = stats_predict(it);
        results_due.push_back(typed ? typed_res : r);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == {REG_ENABLE, 2'b00}) cfg_enable = val[0];
        else cfg_tps = val;
        @(posedge i_clk);
    endtask

    task automatic set_enable(input logic en);
        drain();
        apb_write({REG_ENABLE, 2'b00}, {31'b0, en});
    endtask

    task automatic set_tps(input logic [31:0] tps);
        drain();
        apb_write({REG_TPS, 2'b00}, tps);
    endtask

    function automatic logic pick_start(input int unsigned s);
        return !sl_running[s];
    endfunction

    // one well-formed item for slot s: end if running, else start
    task automatic interval_step(input int unsigned s, input int unsigned spread);
        t_item it;
        int unsigned pick;
        it.timer_id = 4'(s);
        it.op_count = $urandom();
        if (pick_start(s)) begin
            it.action = ACT_START;
            it.timestamp = {$urandom(), $urandom()};
            if ($urandom_range(0, 9) == 0) it.op_count = '0;
        end else begin
            it.action = ACT_END;
            pick = $urandom_range(0, 99);
            if (pick < 85) it.timestamp = sl_stamp[s] + 64'($urandom_range(0, spread));
            else if (pick < 93) it.timestamp = sl_stamp[s] + 64'($urandom());
            else it.timestamp = {$urandom(), $urandom()};
        end
        send_item(it, 1'b0, '0);
    endtask

    // receiver stalls: short mostly, long now and then, none while calm
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if (!calm_mode && $urandom_range(0, 9) == 0)
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                         : $urandom_range(1, 3);
        end
        if (cycle_count > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (results_due.size() == 0) begin
                $display("unexpected result at cycle %0d", cycle_count);
                errors_seen++;
            end else begin
                want = results_due.pop_front();
                if (got.ok != want.ok) report("ok", 64'(got.ok), 64'(want.ok));
                if (got.elapsed != want.elapsed)
                    report("elapsed", 64'(got.elapsed), 64'(want.elapsed));
                if (got.call_total != want.call_total)
                    report("call_total", 64'(got.call_total), 64'(want.call_total));
                if (got.window_fill != want.window_fill)
                    report("window_fill", 64'(got.window_fill), 64'(want.window_fill));
                if (got.window_sum != want.window_sum)
                    report("window_sum", 64'(got.window_sum), 64'(want.window_sum));
                if (got.window_min != want.window_min)
                    report("window_min", 64'(got.window_min), 64'(want.window_min));
                if (got.window_max != want.window_max)
                    report("window_max", 64'(got.window_max), 64'(want.window_max));
                if (got.window_avg != want.window_avg)
                    report("window_avg", 64'(got.window_avg), 64'(want.window_avg));
                if (got.rate != want.rate) report("rate", got.rate, want.rate);
            end
        end
    end

    // stimulus
    initial begin
        t_row rows [$];
        t_item it;
        int unsigned s;
        int unsigned sent;

        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0; in_ch.data = '0;
        i_rst_n = 1'b0;
        calm_mode = 1'b0;
        cfg_enable = 1'b0;
        cfg_tps = TPS_RESET;
        for (int i = 0; i < NSLOT; i++) begin
            sl_used[i] = 0; sl_running[i] = 0; sl_stamp[i] = '0; sl_ops[i] = '0;
            sl_wpos[i] = 0; sl_fill[i] = 0; sl_calls[i] = '0; sl_sum[i] = '0;
            sl_min[i] = '1; sl_max[i] = '0; sl_avg[i] = '0; sl_rate[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        rows = '{
            // disabled after reset: both fail on an empty slot
            '{ROW_ITEM, ACT_START, 4'd0, 64'd100, 32'd9, 1'b1, 32'd0},
            '{ROW_ITEM, ACT_END, 4'd0, 64'd200, 32'd0, 1'b1, 32'd0},
            '{ROW_ENABLE, 1'b0, 4'd0, 64'd0, 32'd0, 1'b0, 32'd1},
            '{ROW_ITEM, ACT_START, 4'd0, 64'd100, 32'hFFFF_FFFF, 1'b0, 32'd0},
            // start while running
            '{ROW_ITEM, ACT_START, 4'd0, 64'd150, 32'd3, 1'b0, 32'd0},
            '{ROW_ITEM, ACT_END, 4'd0, 64'd350, 32'd0, 1'b0, 32'd0},
            // end while not running
            '{ROW_ITEM, ACT_END, 4'd0, 64'd400, 32'd0, 1'b0, 32'd0},
            '{ROW_ITEM, ACT_END, 4'd5, 64'd400, 32'd0, 1'b1, 32'd0},
            // timestamp before the start
            '{ROW_ITEM, ACT_START, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 1'b0, 32'd0},
            '{ROW_ITEM, ACT_END, 4'd15, 64'd0, 32'hFFFF_FFFF, 1'b0, 32'd0},
            // elapsed saturates
            '{ROW_ITEM, ACT_START, 4'd3, 64'd0, 32'd7, 1'b0, 32'd0},
            '{ROW_ITEM, ACT_END, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, 32'd0},
            '{ROW_TPS, 1'b0, 4'd0, 64'd0, 32'd0, 1'b0, 32'd1},
            '{ROW_ITEM, ACT_START, 4'd1, 64'd5, 32'd3, 1'b0, 32'd0},
            '{ROW_ITEM, ACT_END, 4'd1, 64'd9, 32'd0, 1'b0, 32'd0},
            // zero rate scale
            '{ROW_TPS, 1'b0, 4'd0, 64'd0, 32'd0, 1'b0, 32'd0},
            '{ROW_ITEM, ACT_START, 4'd1, 64'd10, 32'd5, 1'b0, 32'd0},
            '{ROW_ITEM, ACT_END, 4'd1, 64'd20, 32'd0, 1'b0, 32'd0},
            '{ROW_TPS, 1'b0, 4'd0, 64'd0, 32'd0, 1'b0, 32'hFFFF_FFFF},
            '{ROW_ITEM, ACT_START, 4'd2, 64'd0, 32'hFFFF_FFFF, 1'b0, 32'd0},
            '{ROW_ITEM, ACT_END, 4'd2, 64'd1, 32'd0, 1'b0, 32'd0},
            // zero ops leaves the rate alone
            '{ROW_ITEM, ACT_START, 4'd2, 64'd7, 32'd0, 1'b0, 32'd0},
            '{ROW_ITEM, ACT_END, 4'd2, 64'd8, 32'd0, 1'b0, 32'd0},
            '{ROW_ENABLE, 1'b0, 4'd0, 64'd0, 32'd0, 1'b0, 32'd0},
            '{ROW_ITEM, ACT_START, 4'd9, 64'd1, 32'd1, 1'b1, 32'd0}
        };
        foreach (rows[i]) begin
            case (rows[i].kind)
                ROW_ENABLE: begin
                    set_enable(rows[i].value[0]);
                end
                ROW_TPS: begin
                    set_tps(rows[i].value);
                end
                default: begin
                    it.action    = rows[i].action;
                    it.timer_id  = rows[i].timer_id;
                    it.timestamp = rows[i].timestamp;
                    it.op_count  = rows[i].op_count;
                    send_item(it, rows[i].typed, empty_fail());
                end
            endcase
        end

        // random intervals, mostly well formed, with some noise and config changes
        set_enable(1'b1);
        set_tps(TPS_RESET);
        sent = 0;
        while (sent < RAND_ITEMS) begin
            if (sent % 60 == 59) calm_mode = ~calm_mode;
            if (sent % 100 == 99) begin
                set_tps(($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom());
                set_enable($urandom_range(0, 4) != 0);
            end
            s = $urandom_range(0, NSLOT - 1);
            if ($urandom_range(0, 99) < 15) begin
                it.action    = 1'($urandom_range(0, 1));
                it.timer_id  = 4'(s);
                it.timestamp = {$urandom(), $urandom()};
                it.op_count  = $urandom();
                send_item(it, 1'b0, '0);
            end else begin
                interval_step(s, 5000);
            end
            sent++;
        end

        // a long run of intervals on one slot to grow its window
        calm_mode = 1'b0;
        set_enable(1'b1);
        set_tps($urandom());
        for (int unsigned i = 0; i < 2 * FILL_PAIRS; i++)
            interval_step(4, 100000);

        drain();
        repeat (20) @(posedge i_clk);
        if (errors_seen == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/wlm_pkg.sv
hw/rtl/wlm_if.sv
hw/rtl/wlm_ram.sv
hw/rtl/windowed_latency_monitor.sv
tb/sv/tb.sv
